@@ rtl/satc_pkg.sv @@
// ----------------------------------------------------------------------------
// satc_pkg: shared types and constants for the source address traffic counter
// Transfer payloads, table sizing and result status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package satc_pkg;

	// Table sizing
	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// Input queue sizing
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int ADDR_W   = 32;
	localparam int LEN_W    = 16;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 3;
	localparam int PKT_W    = 40;
	localparam int BYTE_W   = 48;
	localparam int USED_W   = 7;

	localparam logic [PKT_W-1:0]  PKT_MAX  = {PKT_W{1'b1}};
	localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

	// Command codes
	localparam logic CMD_COUNT = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_HIT     = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NEW     = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_READ_OK = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_UNUSED  = 3'd4;

	typedef struct packed {
		logic               command;
		logic [ADDR_W-1:0]  src_addr;
		logic [LEN_W-1:0]   frame_length;
		logic [INDEX_W-1:0] read_index;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  entry_index;
		logic [ADDR_W-1:0]   entry_addr;
		logic [PKT_W-1:0]    packet_total;
		logic [BYTE_W-1:0]   byte_total;
		logic [USED_W-1:0]   used_entries;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/satc_front.sv @@
// ----------------------------------------------------------------------------
// satc_front: command intake queue
// Accepts command transfers into a short FIFO so bursts can arrive while the
// table engine is still searching for an earlier packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module satc_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire satc_pkg::cmd_t cmd,
	output logic                q_valid,
	output satc_pkg::cmd_t      q_item,
	input  wire logic           q_pop
);
	import satc_pkg::*;

	cmd_t              fifo_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	// Stall when every slot is taken
	assign cmd_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = cmd_valid && !cmd_stall;
	assign q_valid   = (count_q != '0);
	assign pop       = q_pop && q_valid;
	assign q_item    = fifo_q[rd_ptr_q];

	// Store incoming transfers
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/satc_engine.sv @@
// ----------------------------------------------------------------------------
// satc_engine: table search and update engine
// Holds the address and counter memories, scans used entries one per cycle,
// applies saturating updates or appends, and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module satc_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire satc_pkg::cmd_t q_item,
	output logic                q_pop,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output satc_pkg::rsp_t      rsp
);
	import satc_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_UPD    = 3'd2;
	localparam logic [2:0] S_MISS   = 3'd3;
	localparam logic [2:0] S_RDWAIT = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	// Table memories
	logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];
	logic [PKT_W-1:0]  pkt_mem  [TABLE_ENTRIES];
	logic [BYTE_W-1:0] byte_mem [TABLE_ENTRIES];

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	cmd_t              cur_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic [IDX_W-1:0]  scan_idx_d;
	logic [CNT_W-1:0]  fill_q;
	rsp_t              res_q;
	rsp_t              res_d;
	logic              res_load;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_idx;
	logic [ADDR_W-1:0] addr_rd_s1;
	logic [PKT_W-1:0]  pkt_rd_s1;
	logic [BYTE_W-1:0] byte_rd_s1;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [PKT_W-1:0]  wr_pkt;
	logic [BYTE_W-1:0] wr_byte;

	logic [BYTE_W:0]   byte_sum;
	logic [PKT_W-1:0]  pkt_next;
	logic [BYTE_W-1:0] byte_next;
	logic              table_full;
	logic              read_in_use;
	logic              scan_more;
	logic              out_free;
	logic              fill_inc;

	// Saturating counter updates from the registered read data
	assign byte_sum  = {1'b0, byte_rd_s1} + (BYTE_W + 1)'(cur_q.frame_length);
	assign byte_next = byte_sum[BYTE_W] ? BYTE_MAX : byte_sum[BYTE_W-1:0];
	assign pkt_next  = (pkt_rd_s1 == PKT_MAX) ? pkt_rd_s1 : pkt_rd_s1 + 1'b1;

	assign table_full  = (fill_q == CNT_W'(TABLE_ENTRIES));
	assign read_in_use = int'(q_item.read_index) < int'(fill_q);
	assign scan_more   = (int'(scan_idx_q) + 1) < int'(fill_q);
	assign out_free    = !rsp_valid_q || !rsp_stall;

	// Sequence one command at a time
	always_comb begin
		state_d    = state_q;
		scan_idx_d = scan_idx_q;
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		rd_idx     = '0;
		wr_en      = 1'b0;
		wr_idx     = scan_idx_q;
		wr_pkt     = pkt_next;
		wr_byte    = byte_next;
		res_load   = 1'b0;
		res_d      = res_q;
		fill_inc   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.command == CMD_READ) begin
						if (read_in_use) begin
							rd_en   = 1'b1;
							rd_idx  = IDX_W'(q_item.read_index);
							state_d = S_RDWAIT;
						end else begin
							res_load           = 1'b1;
							res_d              = '0;
							res_d.status       = STATUS_UNUSED;
							res_d.entry_index  = q_item.read_index;
							state_d            = S_DONE;
						end
					end else if (fill_q == '0) begin
						state_d = S_MISS;
					end else begin
						rd_en      = 1'b1;
						rd_idx     = '0;
						scan_idx_d = '0;
						state_d    = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (addr_rd_s1 == cur_q.src_addr) begin
					state_d = S_UPD;
				end else if (scan_more) begin
					rd_en      = 1'b1;
					rd_idx     = scan_idx_q + 1'b1;
					scan_idx_d = scan_idx_q + 1'b1;
				end else begin
					state_d = S_MISS;
				end
			end
			S_UPD: begin
				wr_en              = 1'b1;
				res_load           = 1'b1;
				res_d.status       = STATUS_HIT;
				res_d.entry_index  = INDEX_W'(scan_idx_q);
				res_d.entry_addr   = cur_q.src_addr;
				res_d.packet_total = pkt_next;
				res_d.byte_total   = byte_next;
				res_d.used_entries = '0;
				state_d            = S_DONE;
			end
			S_MISS: begin
				res_load = 1'b1;
				if (!table_full) begin
					wr_en              = 1'b1;
					wr_idx             = IDX_W'(fill_q);
					wr_pkt             = PKT_W'(1);
					wr_byte            = BYTE_W'(cur_q.frame_length);
					fill_inc           = 1'b1;
					res_d.status       = STATUS_NEW;
					res_d.entry_index  = INDEX_W'(fill_q);
					res_d.entry_addr   = cur_q.src_addr;
					res_d.packet_total = PKT_W'(1);
					res_d.byte_total   = BYTE_W'(cur_q.frame_length);
				end else begin
					res_d              = '0;
					res_d.status       = STATUS_DROPPED;
					res_d.entry_addr   = cur_q.src_addr;
				end
				res_d.used_entries = '0;
				state_d            = S_DONE;
			end
			S_RDWAIT: begin
				res_load           = 1'b1;
				res_d.status       = STATUS_READ_OK;
				res_d.entry_index  = cur_q.read_index;
				res_d.entry_addr   = addr_rd_s1;
				res_d.packet_total = pkt_rd_s1;
				res_d.byte_total   = byte_rd_s1;
				res_d.used_entries = '0;
				state_d            = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			addr_mem[wr_idx] <= cur_q.src_addr;
			pkt_mem[wr_idx]  <= wr_pkt;
			byte_mem[wr_idx] <= wr_byte;
		end
		if (rd_en) begin
			addr_rd_s1 <= addr_mem[rd_idx];
			pkt_rd_s1  <= pkt_mem[rd_idx];
			byte_rd_s1 <= byte_mem[rd_idx];
		end
	end

	// Hold the current command and the pending result
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		scan_idx_q <= scan_idx_d;
		if (state_q == S_DONE && out_free) begin
			rsp_q <= {res_q[$bits(rsp_t)-1:USED_W], USED_W'(fill_q)};
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ rtl/source_address_traffic_counter.sv @@
// Source address traffic counter. Each command transfer produces exactly one
// response transfer, in command order. A count command scans the used table
// entries in insertion order, one entry per clock through a registered memory
// read, comparing up to 64 entries on a miss into a full table. The scan loop
// over the address memory sets the rate. A four-entry command queue keeps
// taking transfers while a scan runs, and the response register lets the
// engine start the next command while a result waits.
// ----------------------------------------------------------------------------
// source_address_traffic_counter: top level
// Command queue in front of the table engine, with response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module source_address_traffic_counter (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_stall,
	input  wire satc_pkg::cmd_t cmd,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output satc_pkg::rsp_t      rsp
);
	import satc_pkg::*;

	logic q_valid;
	cmd_t q_item;
	logic q_pop;

	// Intake queue
	satc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// Table engine
	satc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Fill count never exceeds the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (int'(rsp.used_entries) <= TABLE_ENTRIES))
		else $error("used_entries above table size");

	// A new entry starts with a packet count of one
	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_NEW) |-> (rsp.packet_total == PKT_W'(1)))
		else $error("new entry packet count not one");

	// Drops only happen with the table full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_DROPPED) |->
			(int'(rsp.used_entries) == TABLE_ENTRIES))
		else $error("drop with table not full");

	// Unused reads return zeroed counters
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == STATUS_UNUSED) |->
			(rsp.packet_total == '0 && rsp.byte_total == '0 && rsp.entry_addr == '0))
		else $error("unused read returned data");

endmodule

`default_nettype wire
